### rtl/mfl_pkg.sv
// ----------------------------------------------------------------------------
// Median filter package
// Shared types and constants of the 3x3 luma median filter.
// ----------------------------------------------------------------------------
package mfl_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
   localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

   // One pending result: median luma, reference pixel {r, g, b}, flags.
   typedef struct packed {
      logic [7:0]  med;
      logic [23:0] refp;
      logic        fend;
      logic        last;
   } task_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

### rtl/mfl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/mfl_front.sv
// ----------------------------------------------------------------------------
// Median filter front end
// Accepts pixels, keeps the line stores and the luma window, and queues one
// task per result with its median and reference pixel.
// ----------------------------------------------------------------------------
module mfl_front
   import mfl_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [47:0]    req_tdata,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_data,
   output logic           push,
   output task_type       push_data,
   input  queue_stat_type q_stat
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   localparam logic [17:0] C_R = 18'd299;
   localparam logic [17:0] C_G = 18'd587;
   localparam logic [17:0] C_B = 18'd114;
   // ceil(2^28 / 1000); exact for sums up to 255000.
   localparam logic [18:0] RECIP_1000 = 19'd268436;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [10:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;

   logic [17:0] sum_ff, sum_in;
   logic [23:0] refp_ff, refp_in;
   logic [COL_W-1:0] x_ff, x_in;
   logic        cs_ff, cs_in;
   logic        ge1_ff, ge1_in;
   logic        ge2_ff, ge2_in;
   logic        lcol_ff, lcol_in;
   logic        lrow_ff, lrow_in;
   logic [3:0]  mask_ff, mask_in;
   logic [47:0] cur_word_ff, cur_word_in;
   logic [47:0] prev_word_ff, prev_word_in;
   logic [7:0]  win_ff [9];
   logic [7:0]  win_in [9];

   logic [COL_W-1:0] last_col;
   logic [15:0] last_row;
   logic [31:0] wide_w;
   logic        req_acc;
   logic [36:0] luma_prod;
   logic [7:0]  cur;
   logic [15:0] luma_rd, luma_wr;
   logic [47:0] ref_rd;
   logic [7:0]  a1, a2, top, mid;
   logic [3:0]  sel, remain;
   logic        edge_col, last_rows;
   logic [7:0]  v0, v1, v2, v3, v4, v5, v6, v7, v8;
   logic [23:0] prev_ps, prev_cs, cur_ps, cur_cs;

   // Effective last column and last row of the frame.
   always_comb begin
      wide_w = {21'd0, width_ff};
      if (width_ff == 11'd0) begin
         last_col = '0;
      end else if (wide_w >= MAX_WIDTH) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(wide_w - 32'd1);
      end
      last_row = (height_ff == 16'd0) ? 16'd0 : height_ff - 16'd1;
   end

   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign luma_prod = {19'd0, sum_ff} * {18'd0, RECIP_1000};
   assign cur       = luma_prod[35:28];

   mfl_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_luma_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_CALC),
      .wr_addr (x_ff),
      .wr_data (luma_wr),
      .rd_en   (req_acc),
      .rd_addr (col_ff),
      .rd_data (luma_rd)
   );

   mfl_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_ref_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_CALC),
      .wr_addr (x_ff),
      .wr_data (cur_word_in),
      .rd_en   (req_acc),
      .rd_addr (col_ff),
      .rd_data (ref_rd)
   );

   // Each entry holds both rows of one column; the even row sits low.
   always_comb begin
      a2      = cs_ff ? luma_rd[15:8] : luma_rd[7:0];
      a1      = cs_ff ? luma_rd[7:0]  : luma_rd[15:8];
      luma_wr = cs_ff ? {cur, luma_rd[7:0]} : {luma_rd[15:8], cur};
      top     = ge2_ff ? a2 : (ge1_ff ? a1 : cur);
      mid     = ge1_ff ? a1 : cur;
   end

   always_comb begin
      prev_ps = cs_ff ? prev_word_ff[23:0]  : prev_word_ff[47:24];
      prev_cs = cs_ff ? prev_word_ff[47:24] : prev_word_ff[23:0];
      cur_ps  = cs_ff ? cur_word_ff[23:0]   : cur_word_ff[47:24];
      cur_cs  = cs_ff ? cur_word_ff[47:24]  : cur_word_ff[23:0];
   end

   // Lowest pending task goes first.
   assign sel       = mask_ff & (~mask_ff + 4'd1);
   assign remain    = mask_ff & ~sel;
   assign edge_col  = sel[1] || sel[3];
   assign last_rows = sel[2] || sel[3];

   // Window index is row * 3 + column.
   always_comb begin
      v0 = last_rows ? win_ff[edge_col ? 4 : 3] : win_ff[edge_col ? 1 : 0];
      v1 = last_rows ? win_ff[edge_col ? 5 : 4] : win_ff[edge_col ? 2 : 1];
      v2 = last_rows ? win_ff[5] : win_ff[2];
      v3 = last_rows ? win_ff[edge_col ? 7 : 6] : win_ff[edge_col ? 4 : 3];
      v4 = last_rows ? win_ff[edge_col ? 8 : 7] : win_ff[edge_col ? 5 : 4];
      v5 = last_rows ? win_ff[8] : win_ff[5];
      v6 = win_ff[edge_col ? 7 : 6];
      v7 = win_ff[edge_col ? 8 : 7];
      v8 = win_ff[8];
   end

   function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Median of nine: row minima, medians and maxima, then the median of
   // the largest minimum, the middle median and the smallest maximum.
   function automatic logic [7:0] med9(input logic [7:0] p0, input logic [7:0] p1,
                                       input logic [7:0] p2, input logic [7:0] p3,
                                       input logic [7:0] p4, input logic [7:0] p5,
                                       input logic [7:0] p6, input logic [7:0] p7,
                                       input logic [7:0] p8);
      logic [7:0] lo, md, hi;
      lo = max2(max2(min2(min2(p0, p1), p2), min2(min2(p3, p4), p5)),
                min2(min2(p6, p7), p8));
      md = med3(med3(p0, p1, p2), med3(p3, p4, p5), med3(p6, p7, p8));
      hi = min2(min2(max2(max2(p0, p1), p2), max2(max2(p3, p4), p5)),
                max2(max2(p6, p7), p8));
      return med3(lo, md, hi);
   endfunction

   always_comb begin
      push_data.med  = med9(v0, v1, v2, v3, v4, v5, v6, v7, v8);
      unique case (1'b1)
         sel[1]:  push_data.refp = cur_ps;
         sel[2]:  push_data.refp = prev_cs;
         sel[3]:  push_data.refp = cur_cs;
         default: push_data.refp = prev_ps;
      endcase
      push_data.fend = sel[3];
      push_data.last = (remain == 4'd0);
   end

   assign push = (state_ff == S_EMIT) && !q_stat.full;

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sum_in       = sum_ff;
      refp_in      = refp_ff;
      x_in         = x_ff;
      cs_in        = cs_ff;
      ge1_in       = ge1_ff;
      ge2_in       = ge2_ff;
      lcol_in      = lcol_ff;
      lrow_in      = lrow_ff;
      mask_in      = mask_ff;
      prev_word_in = prev_word_ff;
      cur_word_in  = cs_ff ? {refp_ff, ref_rd[23:0]} : {ref_rd[47:24], refp_ff};
      win_in       = win_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_index == REG_IMAGE_WIDTH) begin
                  width_in = csr_data[10:0];
                  col_in   = '0;
                  row_in   = '0;
               end else if (csr_index == REG_IMAGE_HEIGHT) begin
                  height_in = csr_data;
                  col_in    = '0;
                  row_in    = '0;
               end
            end else if (req_acc) begin
               sum_in  = C_R * {10'd0, req_tdata[7:0]} + C_G * {10'd0, req_tdata[15:8]}
                       + C_B * {10'd0, req_tdata[23:16]};
               refp_in = {req_tdata[31:24], req_tdata[39:32], req_tdata[47:40]};
               x_in    = col_ff;
               cs_in   = row_ff[0];
               ge1_in  = (row_ff != 16'd0);
               ge2_in  = (row_ff > 16'd1);
               lcol_in = (col_ff == last_col);
               lrow_in = (row_ff == last_row);
               if (col_ff == last_col) begin
                  col_in = '0;
                  row_in = (row_ff == last_row) ? 16'd0 : row_ff + 16'd1;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            prev_word_in = cur_word_ff;
            for (int i = 0; i < 3; i++) begin
               if (x_ff == '0) begin
                  win_in[i*3]   = (i == 0) ? top : ((i == 1) ? mid : cur);
                  win_in[i*3+1] = (i == 0) ? top : ((i == 1) ? mid : cur);
               end else begin
                  win_in[i*3]   = win_ff[i*3+1];
                  win_in[i*3+1] = win_ff[i*3+2];
               end
               win_in[i*3+2] = (i == 0) ? top : ((i == 1) ? mid : cur);
            end
            mask_in[0] = ge1_ff && (x_ff != '0);
            mask_in[1] = ge1_ff && lcol_ff;
            mask_in[2] = lrow_ff && (x_ff != '0);
            mask_in[3] = lrow_ff && lcol_ff;
            state_in   = (mask_in != 4'd0) ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (push) begin
               mask_in  = remain;
               state_in = (remain == 4'd0) ? S_IDLE : S_EMIT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         mask_ff   <= '0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         mask_ff   <= mask_in;
         win_ff    <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      refp_ff      <= refp_in;
      x_ff         <= x_in;
      cs_ff        <= cs_in;
      ge1_ff       <= ge1_in;
      ge2_ff       <= ge2_in;
      lcol_ff      <= lcol_in;
      lrow_ff      <= lrow_in;
      prev_word_ff <= prev_word_in;
      if (state_ff == S_CALC) begin
         cur_word_ff <= cur_word_in;
      end
   end

endmodule

### rtl/mfl_queue.sv
// ----------------------------------------------------------------------------
// Task queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mfl_queue
   import mfl_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  task_type       push_data,
   input  logic           pop,
   output task_type       head,
   output queue_stat_type q_stat
);

   localparam int PTR_W = $clog2(DEPTH);

   task_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign q_stat.full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/mfl_back.sv
// ----------------------------------------------------------------------------
// Median filter back end
// Rebuilds RGB from the median luma and the reference chroma in a stalling
// three-stage pipeline and drives the result channel.
// ----------------------------------------------------------------------------
module mfl_back
   import mfl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  task_type       head,
   input  queue_stat_type q_stat,
   output logic           pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [23:0]    rsp_tdata,
   output logic           rsp_tlast,
   output logic           rsp_tuser
);

   // Chroma scaled by 10^4; the result is floor((M * 10^7 + c * chroma) / 10^7).
   localparam logic signed [33:0] SCALE    = 34'sd10000000;
   localparam logic signed [33:0] CLAMP_HI = 34'sd2560000000;
   // ceil(2^42 / 78125); t / 10^7 = (t >> 7) / 78125.
   localparam logic [25:0] RECIP = 26'd56294996;

   logic              en;
   logic              s1_vld_ff, s2_vld_ff, rsp_vld_ff;
   logic [7:0]        s1_med_ff, s1_med_in;
   logic signed [21:0] s1_u_ff, s1_u_in, s1_v_ff, s1_v_in;
   logic [1:0]        s1_flags_ff, s2_flags_ff;
   logic signed [33:0] s2_r_ff, s2_r_in, s2_g_ff, s2_g_in, s2_b_ff, s2_b_in;
   logic [23:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_flags_ff;

   assign en  = !rsp_vld_ff || rsp_tready;
   assign pop = en && !q_stat.empty;

   always_comb begin
      logic signed [21:0] rr, rg, rb;
      rr = $signed({14'd0, head.refp[23:16]});
      rg = $signed({14'd0, head.refp[15:8]});
      rb = $signed({14'd0, head.refp[7:0]});
      s1_med_in = head.med;
      s1_u_in   = -22'sd1690 * rr - 22'sd3320 * rg + 22'sd5000 * rb;
      s1_v_in   =  22'sd5000 * rr - 22'sd4190 * rg - 22'sd813 * rb;
   end

   always_comb begin
      logic signed [33:0] base, u, v;
      base    = $signed({26'd0, s1_med_ff}) * SCALE;
      u       = 34'(s1_u_ff);
      v       = 34'(s1_v_ff);
      s2_r_in = base + 34'sd1403 * v;
      s2_g_in = base - 34'sd344 * u - 34'sd714 * v;
      s2_b_in = base + 34'sd1770 * u;
   end

   function automatic logic [7:0] to_byte(input logic signed [33:0] t);
      logic [50:0] prod;
      prod = {26'd0, t[31:7]} * {25'd0, RECIP};
      if (t < 34'sd0) begin
         return 8'd0;
      end else if (t >= CLAMP_HI) begin
         return 8'd255;
      end else begin
         return prod[49:42];
      end
   endfunction

   assign rsp_data_in = {to_byte(s2_b_ff), to_byte(s2_g_ff), to_byte(s2_r_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= !q_stat.empty;
         s2_vld_ff  <= s1_vld_ff;
         rsp_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_med_ff    <= s1_med_in;
         s1_u_ff      <= s1_u_in;
         s1_v_ff      <= s1_v_in;
         s1_flags_ff  <= {head.fend, head.last};
         s2_r_ff      <= s2_r_in;
         s2_g_ff      <= s2_g_in;
         s2_b_ff      <= s2_b_in;
         s2_flags_ff  <= s1_flags_ff;
         rsp_data_ff  <= rsp_data_in;
         rsp_flags_ff <= s2_flags_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_flags_ff[0];
   assign rsp_tuser  = rsp_flags_ff[1];

endmodule

### rtl/median3x3_luma_filter_core.sv
// ----------------------------------------------------------------------------
// 3x3 luma median filter core
// Raster RGB in with a reference pixel, median-filtered luma with reference
// chroma out.
// ----------------------------------------------------------------------------
// Each source pixel becomes luma, the 3x3 median with replicated borders is
// taken, and RGB is rebuilt from it and the chroma of the reference pixel.
// A pixel occupies the front end for a line store read, then the
// read-modify-write of the column entry and window update, and then one
// emit step per result it releases, since one shared median unit serves up
// to four results; the back end takes one result per cycle unless stalled. The
// line stores are not cleared after reset: every entry is written in the
// current frame before it is used. Writing either register restarts the frame.
module median3x3_luma_filter_core
   import mfl_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // src_red, src_green, src_blue, ref_red, ref_green, ref_blue
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   // frame_end
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic           push, pop;
   task_type       push_data, head;
   queue_stat_type q_stat;

   mfl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_data  (push_data),
      .q_stat     (q_stat)
   );

   mfl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   mfl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/mfl_checker.sv
// ----------------------------------------------------------------------------
// Median filter checker
// Port-level assertions on the filter core, attached by bind.
// ----------------------------------------------------------------------------
module mfl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_data
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The final pixel of a frame is always the last result of its transaction.
   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without last");

   // The front end is busy in the cycle after taking a pixel.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !csr_ready)
      else $error("pixel accepted back to back");

   // A configuration write and a pixel are never taken together.
   a_csr_excl: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !req_tready)
      else $error("pixel taken during configuration write");

endmodule

bind median3x3_luma_filter_core mfl_checker u_mfl_checker (.*);
